>>> src/rss_pkg.sv
// Shared constants, codes and control types of the request slot scheduler.
package rss_pkg;

  // Build default for the number of slots
  localparam int DEPTH_DEFAULT = 16;

  // Field widths
  localparam int HANDLE_W   = 16;
  localparam int NAME_W     = 13;
  localparam int SIZE_W     = 23;
  localparam int STATUS_W   = 3;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Key limits: name must stay below, size may reach its limit
  localparam logic [31:0] NAME_LIMIT = 32'd8192;
  localparam logic [31:0] SIZE_LIMIT = 32'd8192000;

  // Reset value of the slot count register
  localparam logic [CFG_DATA_W-1:0] SLOTS_RESET = 5'd16;

  // Request codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KEY_LARGE = 3'd4;

  // Take policies (the unused code behaves as FIFO)
  localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_NAME = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_SIZE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 1'b1;

  // Slot store commands
  typedef struct packed {
    logic write;      // store the held request at the address, mark valid
    logic clear_one;  // free the slot at the address
  } rss_mem_cmd_t;

  // Minimum search unit commands
  typedef struct packed {
    logic init;       // forget the current best
    logic step;       // a key from the store is present this cycle
    logic key_valid;  // that key belongs to an occupied slot
  } rss_min_cmd_t;

endpackage

>>> src/rss_slot_mem.sv
// Slot store: handle and key memories plus per-slot occupancy bits.
module rss_slot_mem #(
  parameter int DEPTH = rss_pkg::DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear_all,
  input  rss_pkg::rss_mem_cmd_t       cmd,
  input  logic [IW-1:0]               addr,
  input  logic [rss_pkg::HANDLE_W-1:0] wr_handle,
  input  logic [rss_pkg::NAME_W-1:0]  wr_name,
  input  logic [rss_pkg::SIZE_W-1:0]  wr_size,
  input  logic                        key_by_name,
  output logic [DEPTH-1:0]            valid,
  output logic [rss_pkg::HANDLE_W-1:0] rd_handle,
  output logic [rss_pkg::SIZE_W-1:0]  rd_key
);
  import rss_pkg::*;

  logic [HANDLE_W-1:0] handle_mem [DEPTH];
  logic [NAME_W-1:0]   name_mem   [DEPTH];
  logic [SIZE_W-1:0]   size_mem   [DEPTH];

  // One write port, one registered read port at the same address
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      handle_mem[addr] <= wr_handle;
      name_mem[addr]   <= wr_name;
      size_mem[addr]   <= wr_size;
    end
    rd_handle <= handle_mem[addr];
    rd_key    <= key_by_name ? SIZE_W'(name_mem[addr]) : size_mem[addr];
  end

  // Occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear_all) begin
      valid <= '0;
    end else begin
      if (cmd.write) begin
        valid[addr] <= 1'b1;
      end
      if (cmd.clear_one) begin
        valid[addr] <= 1'b0;
      end
    end
  end

endmodule

>>> src/rss_min_unit.sv
// Shared compare unit: running minimum key over a slot scan, ties to the first seen.
module rss_min_unit #(
  parameter int DEPTH = rss_pkg::DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rss_pkg::rss_min_cmd_t      cmd,
  input  logic [IW-1:0]              idx,
  input  logic [rss_pkg::SIZE_W-1:0] key,
  output logic [IW-1:0]              best_idx
);
  import rss_pkg::*;

  logic              found;
  logic [SIZE_W-1:0] best_key;
  logic              take_new;

  // Strict less-than keeps the lowest slot on a tie
  assign take_new = cmd.step && cmd.key_valid && (!found || (key < best_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.init) begin
      found <= 1'b0;
    end else if (take_new) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new && !cmd.init) begin
      best_key <= key;
      best_idx <= idx;
    end
  end

endmodule

>>> src/rss_seq.sv
// Sequencer: request decode, slot scans, pointers, entry count and result register.
module rss_seq #(
  parameter int DEPTH = rss_pkg::DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear_all,
  input  logic [rss_pkg::POLICY_W-1:0] policy,
  input  logic [CW-1:0]                n,
  // request channel
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         func,
  input  logic [rss_pkg::HANDLE_W-1:0] handle,
  input  logic [rss_pkg::NAME_W-1:0]   name_key,
  input  logic [rss_pkg::SIZE_W-1:0]   size_key,
  // response channel
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [rss_pkg::STATUS_W-1:0] status,
  output logic [rss_pkg::HANDLE_W-1:0] handle_out,
  output logic [IW-1:0]                slot,
  // slot store
  output rss_pkg::rss_mem_cmd_t        mem_cmd,
  output logic [IW-1:0]                mem_addr,
  output logic [rss_pkg::HANDLE_W-1:0] wr_handle,
  output logic [rss_pkg::NAME_W-1:0]   wr_name,
  output logic [rss_pkg::SIZE_W-1:0]   wr_size,
  output logic                         key_by_name,
  input  logic [DEPTH-1:0]             valid,
  input  logic [rss_pkg::HANDLE_W-1:0] rd_handle,
  // minimum unit
  output rss_pkg::rss_min_cmd_t        min_cmd,
  output logic [IW-1:0]                min_idx,
  input  logic [IW-1:0]                best_idx
);
  import rss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT_SCAN,
    S_FIFO_SCAN,
    S_MIN_SCAN,
    S_MIN_DRAIN,
    S_MIN_PICK,
    S_READ,
    S_FETCH,
    S_RESP
  } state_t;

  state_t        state;
  logic [IW-1:0] cursor;
  logic [IW-1:0] sel;
  logic [IW-1:0] put_ptr;
  logic [IW-1:0] take_ptr;
  logic [CW-1:0] count;
  logic [IW-1:0] tag_idx;
  logic          tag_valid;
  logic          tag_live;
  logic [IW-1:0] n_last;
  logic [IW-1:0] cursor_inc;
  logic          key_big;
  logic          by_min;

  // Wrap point of the active slot range
  assign n_last     = IW'(n - CW'(1));
  assign cursor_inc = (cursor == n_last) ? '0 : cursor + IW'(1);

  assign key_big = (32'(name_key) >= NAME_LIMIT) || (32'(size_key) > SIZE_LIMIT);
  assign by_min  = (policy == POLICY_NAME) || (policy == POLICY_SIZE);

  assign req_ready = (state == S_IDLE);

  // Store and compare unit control
  assign mem_cmd.write     = (state == S_PUT_SCAN) && !valid[cursor];
  assign mem_cmd.clear_one = (state == S_READ);
  assign mem_addr          = (state == S_READ) ? sel : cursor;
  assign min_cmd.init      = (state == S_IDLE);
  assign min_cmd.step      = tag_live;
  assign min_cmd.key_valid = tag_valid;
  assign min_idx           = tag_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      put_ptr   <= '0;
      take_ptr  <= '0;
      count     <= '0;
      tag_live  <= 1'b0;
    end else begin
      tag_live <= 1'b0;
      if (clear_all) begin
        put_ptr  <= '0;
        take_ptr <= '0;
        count    <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            wr_handle   <= handle;
            wr_name     <= name_key;
            wr_size     <= size_key;
            key_by_name <= (policy == POLICY_NAME);
            handle_out  <= '0;
            slot        <= '0;
            if (func == FUNC_PUT) begin
              if (key_big) begin
                status    <= ST_KEY_LARGE;
                rsp_valid <= 1'b1;
                state     <= S_RESP;
              end else if (count >= n) begin
                status    <= ST_FULL;
                rsp_valid <= 1'b1;
                state     <= S_RESP;
              end else begin
                cursor <= put_ptr;
                state  <= S_PUT_SCAN;
              end
            end else begin
              if (count == '0) begin
                status    <= ST_EMPTY;
                rsp_valid <= 1'b1;
                state     <= S_RESP;
              end else if (by_min) begin
                cursor <= '0;
                state  <= S_MIN_SCAN;
              end else begin
                cursor <= take_ptr;
                state  <= S_FIFO_SCAN;
              end
            end
          end
        end
        // first free slot from the put pointer; one is known to exist
        S_PUT_SCAN: begin
          if (!valid[cursor]) begin
            put_ptr   <= cursor_inc;
            count     <= count + CW'(1);
            status    <= ST_STORED;
            slot      <= cursor;
            rsp_valid <= 1'b1;
            state     <= S_RESP;
          end else begin
            cursor <= cursor_inc;
          end
        end
        // first occupied slot from the take pointer
        S_FIFO_SCAN: begin
          if (valid[cursor]) begin
            sel      <= cursor;
            take_ptr <= cursor_inc;
            state    <= S_READ;
          end else begin
            cursor <= cursor_inc;
          end
        end
        // read keys in slot order; each key is compared in the cycle after its read
        S_MIN_SCAN: begin
          tag_idx   <= cursor;
          tag_valid <= valid[cursor];
          tag_live  <= 1'b1;
          if (cursor == n_last) begin
            state <= S_MIN_DRAIN;
          end else begin
            cursor <= cursor_inc;
          end
        end
        S_MIN_DRAIN: begin
          state <= S_MIN_PICK;
        end
        S_MIN_PICK: begin
          sel   <= best_idx;
          state <= S_READ;
        end
        // free the chosen slot, handle read is in flight
        S_READ: begin
          count <= count - CW'(1);
          state <= S_FETCH;
        end
        S_FETCH: begin
          status     <= ST_TAKEN;
          handle_out <= rd_handle;
          slot       <= sel;
          rsp_valid  <= 1'b1;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/request_slot_scheduler_unit.sv
// Request slot scheduler top level: configuration registers and unit wiring.
//
// Usage: a bounded buffer of pending requests. A request word with func put
// stores handle, name_key and size_key in the first free slot at or after the
// rotating put pointer; a word with func take removes one entry chosen by the
// policy register (FIFO, smallest name key, smallest size key; ties to the
// lowest slot). Every request word gives exactly one response word with
// status, handle_out and slot. Full, empty and oversized keys are reported in
// status; nothing blocks.
// Channels: req_* and rsp_* are valid/ready; cfg_* writes register cfg_index
// (0 policy, 1 slots_in_use) and is always ready. Writing slots_in_use empties
// the buffer. Configure only while no request is in flight.
// Timing: one request at a time; req_ready is high only while idle. A
// rejected word needs no scan; a put scans from the put pointer to the first
// free slot, a FIFO take from the take pointer to the first occupied slot,
// a smallest-key take all n active slots, one slot per cycle through the slot
// store and the shared compare unit. req_ready rises in the cycle after the rsp handshake.
// Reset: buffer empty, pointers zero, policy FIFO, slots_in_use 16. If the
// receiver stalls, the response word holds and no new request is taken.
module request_slot_scheduler_unit #(
  parameter int DEPTH = rss_pkg::DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
  // request
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           func,
  input  logic [rss_pkg::HANDLE_W-1:0]   handle,
  input  logic [rss_pkg::NAME_W-1:0]     name_key,
  input  logic [rss_pkg::SIZE_W-1:0]     size_key,
  // response
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [rss_pkg::STATUS_W-1:0]   status,
  output logic [rss_pkg::HANDLE_W-1:0]   handle_out,
  output logic [IW-1:0]                  slot
);
  import rss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [POLICY_W-1:0]   policy;
  logic [CFG_DATA_W-1:0] slots_in_use;
  logic                  clear_all;
  logic [31:0]           slots_ext;
  logic [CW-1:0]         n;

  rss_mem_cmd_t          mem_cmd;
  logic [IW-1:0]         mem_addr;
  logic [HANDLE_W-1:0]   wr_handle;
  logic [NAME_W-1:0]     wr_name;
  logic [SIZE_W-1:0]     wr_size;
  logic                  key_by_name;
  logic [DEPTH-1:0]      valid;
  logic [HANDLE_W-1:0]   rd_handle;
  logic [SIZE_W-1:0]     rd_key;
  rss_min_cmd_t          min_cmd;
  logic [IW-1:0]         min_idx;
  logic [IW-1:0]         best_idx;

  assign cfg_ready = 1'b1;
  assign clear_all = cfg_valid && (cfg_index == REG_SLOTS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POLICY_FIFO;
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POLICY: policy       <= cfg_data[POLICY_W-1:0];
        REG_SLOTS:  slots_in_use <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Active slot count, clamped to 1..DEPTH
  assign slots_ext = 32'(slots_in_use);
  always_comb begin
    if (slots_ext == 32'd0) begin
      n = CW'(1);
    end else if (slots_ext > 32'(DEPTH)) begin
      n = CW'(DEPTH);
    end else begin
      n = CW'(slots_ext);
    end
  end

  rss_seq #(.DEPTH(DEPTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .clear_all   (clear_all),
    .policy      (policy),
    .n           (n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .handle      (handle),
    .name_key    (name_key),
    .size_key    (size_key),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .handle_out  (handle_out),
    .slot        (slot),
    .mem_cmd     (mem_cmd),
    .mem_addr    (mem_addr),
    .wr_handle   (wr_handle),
    .wr_name     (wr_name),
    .wr_size     (wr_size),
    .key_by_name (key_by_name),
    .valid       (valid),
    .rd_handle   (rd_handle),
    .min_cmd     (min_cmd),
    .min_idx     (min_idx),
    .best_idx    (best_idx)
  );

  rss_slot_mem #(.DEPTH(DEPTH)) u_slot_mem (
    .clk         (clk),
    .rst         (rst),
    .clear_all   (clear_all),
    .cmd         (mem_cmd),
    .addr        (mem_addr),
    .wr_handle   (wr_handle),
    .wr_name     (wr_name),
    .wr_size     (wr_size),
    .key_by_name (key_by_name),
    .valid       (valid),
    .rd_handle   (rd_handle),
    .rd_key      (rd_key)
  );

  rss_min_unit #(.DEPTH(DEPTH)) u_min_unit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (min_cmd),
    .idx      (min_idx),
    .key      (rd_key),
    .best_idx (best_idx)
  );

endmodule
